// ===== rtl/core/dqs_pkg.sv =====
// ----------------------------------------------------------------------------
// dqs_pkg
// Shared types and codes for the double-ended queue with search: the beat
// formats of both channels, the command codes and the status codes.
// ----------------------------------------------------------------------------
package dqs_pkg;

  localparam int DEPTH_DEFAULT = 256;
  localparam int DATA_W        = 32;
  localparam int OCC_W         = 9;

  localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [2:0] CMD_POP_BACK   = 3'd3;
  localparam logic [2:0] CMD_SEARCH     = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]               cmd;
    logic signed [DATA_W-1:0] value;
  } req_beat_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] popped_value;
    logic                     found;
    logic [OCC_W-1:0]         occupancy;
  } rsp_beat_t;

endpackage

// ===== rtl/core/dqs_store.sv =====
// ----------------------------------------------------------------------------
// dqs_store
// Circular entry store: one write port and one read port with registered
// read data, so a read returns its entry in the cycle after the address.
// ----------------------------------------------------------------------------
module dqs_store #(
  parameter int DEPTH = dqs_pkg::DEPTH_DEFAULT,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [dqs_pkg::DATA_W-1:0] wdata,
  input  logic [AW-1:0]              raddr,
  output logic [dqs_pkg::DATA_W-1:0] rdata
);

  logic [dqs_pkg::DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/dqs_ctrl.sv =====
// ----------------------------------------------------------------------------
// dqs_ctrl
// Command sequencer: keeps the front index and the count, issues store
// writes for pushes and reads for pops, and walks the live entries one per
// cycle for a search. Holds each result until the output register takes it.
// ----------------------------------------------------------------------------
module dqs_ctrl #(
  parameter int DEPTH = dqs_pkg::DEPTH_DEFAULT,
  parameter int AW    = $clog2(DEPTH),
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  dqs_pkg::req_beat_t         in_beat,
  output logic                       in_stall,
  output logic                       res_valid,
  output dqs_pkg::rsp_beat_t         res,
  input  logic                       res_ready,
  output logic                       we,
  output logic [AW-1:0]              waddr,
  output logic [dqs_pkg::DATA_W-1:0] wdata,
  output logic [AW-1:0]              raddr,
  input  logic [dqs_pkg::DATA_W-1:0] rdata
);

  localparam int SW = CW + 1;
  localparam int XW = (CW > dqs_pkg::OCC_W) ? CW : dqs_pkg::OCC_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_SCAN = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t                     state;
  logic [AW-1:0]              front;
  logic [CW-1:0]              count;
  logic [CW-1:0]              left;
  logic [AW-1:0]              ptr;
  logic [dqs_pkg::DATA_W-1:0] key;
  logic [1:0]                 status;
  logic [dqs_pkg::DATA_W-1:0] popped;
  logic                       found;

  logic          accept;
  logic          is_full;
  logic          is_empty;
  logic [AW-1:0] front_dec;
  logic [AW-1:0] front_inc;
  logic [AW-1:0] ptr_inc;
  logic [SW-1:0] back_sum;
  logic [SW-1:0] last_sum;
  logic [SW-1:0] back_wrap;
  logic [SW-1:0] last_wrap;
  logic [AW-1:0] back_addr;
  logic [AW-1:0] last_addr;
  logic [XW-1:0] count_ext;

  assign accept   = in_valid && (state == S_IDLE);
  assign in_stall = (state != S_IDLE);
  assign is_full  = (count == CW'(DEPTH));
  assign is_empty = (count == '0);

  assign front_dec = (front == '0) ? AW'(DEPTH - 1) : front - AW'(1);
  assign front_inc = (front == AW'(DEPTH - 1)) ? '0 : front + AW'(1);
  assign ptr_inc   = (ptr == AW'(DEPTH - 1)) ? '0 : ptr + AW'(1);

  assign back_sum  = SW'(front) + SW'(count);
  assign last_sum  = back_sum - SW'(1);
  assign back_wrap = (back_sum >= SW'(DEPTH)) ? back_sum - SW'(DEPTH) : back_sum;
  assign last_wrap = (last_sum >= SW'(DEPTH)) ? last_sum - SW'(DEPTH) : last_sum;
  assign back_addr = back_wrap[AW-1:0];
  assign last_addr = last_wrap[AW-1:0];

  assign we    = accept && !is_full &&
                 (in_beat.cmd == dqs_pkg::CMD_PUSH_FRONT ||
                  in_beat.cmd == dqs_pkg::CMD_PUSH_BACK);
  assign waddr = (in_beat.cmd == dqs_pkg::CMD_PUSH_FRONT) ? front_dec : back_addr;
  assign wdata = in_beat.value;

  always_comb begin
    if (state == S_SCAN) begin
      raddr = ptr;
    end else if (in_beat.cmd == dqs_pkg::CMD_POP_BACK) begin
      raddr = last_addr;
    end else begin
      raddr = front;
    end
  end

  assign count_ext        = XW'(count);
  assign res_valid        = (state == S_DONE);
  assign res.status       = status;
  assign res.popped_value = popped;
  assign res.found        = found;
  assign res.occupancy    = count_ext[dqs_pkg::OCC_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      front <= '0;
      count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            key    <= in_beat.value;
            status <= dqs_pkg::ST_OK;
            popped <= '0;
            found  <= 1'b0;
            state  <= S_DONE;
            case (in_beat.cmd)
              dqs_pkg::CMD_PUSH_FRONT: begin
                if (is_full) begin
                  status <= dqs_pkg::ST_FULL;
                end else begin
                  front <= front_dec;
                  count <= count + CW'(1);
                end
              end
              dqs_pkg::CMD_PUSH_BACK: begin
                if (is_full) begin
                  status <= dqs_pkg::ST_FULL;
                end else begin
                  count <= count + CW'(1);
                end
              end
              dqs_pkg::CMD_POP_FRONT: begin
                if (is_empty) begin
                  status <= dqs_pkg::ST_EMPTY;
                end else begin
                  front <= front_inc;
                  count <= count - CW'(1);
                  state <= S_READ;
                end
              end
              dqs_pkg::CMD_POP_BACK: begin
                if (is_empty) begin
                  status <= dqs_pkg::ST_EMPTY;
                end else begin
                  count <= count - CW'(1);
                  state <= S_READ;
                end
              end
              dqs_pkg::CMD_SEARCH: begin
                if (is_empty) begin
                  status <= dqs_pkg::ST_EMPTY;
                end else begin
                  ptr   <= front_inc;
                  left  <= count;
                  state <= S_SCAN;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_READ: begin
          popped <= rdata;
          state  <= S_DONE;
        end
        S_SCAN: begin
          ptr <= ptr_inc;
          if (rdata == key) begin
            found <= 1'b1;
            state <= S_DONE;
          end else if (left == CW'(1)) begin
            state <= S_DONE;
          end else begin
            left <= left - CW'(1);
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("count exceeds depth");

  a_front_bound: assert property (@(posedge clk) disable iff (rst)
    SW'(front) < SW'(DEPTH))
    else $error("front index out of range");

  a_scan_left: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (left != '0))
    else $error("search walk with no entries left");

  a_done_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |=> $stable(count) && $stable(front))
    else $error("queue changed while a result was pending");

  a_search_walk: assert property (@(posedge clk) disable iff (rst)
    (accept && in_beat.cmd == dqs_pkg::CMD_SEARCH && !is_empty) |=> (state == S_SCAN))
    else $error("search on a non-empty queue did not start a walk");

endmodule

// ===== rtl/core/deque_with_search_core.sv =====
// ----------------------------------------------------------------------------
// deque_with_search_core
// Bounded double-ended queue of signed 32-bit values in a circular store,
// with push and pop at both ends and a search for a key.
// Pushes, failing commands and undefined commands pass from acceptance to the
// output register through S_DONE, pops through S_READ and S_DONE, and a search
// through S_SCAN and S_DONE. One item at a time: S_SCAN walks the store's single
// read port one entry a cycle, and a new beat is stalled until S_DONE is left.
// Reset clears the front index, the count and the output valid; the store
// is not cleared and the block accepts a beat on the first cycle after reset.
// ----------------------------------------------------------------------------
module deque_with_search_core #(
  parameter int DEPTH = dqs_pkg::DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  dqs_pkg::req_beat_t req,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output dqs_pkg::rsp_beat_t rsp
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic                       we;
  logic [AW-1:0]              waddr;
  logic [dqs_pkg::DATA_W-1:0] wdata;
  logic [AW-1:0]              raddr;
  logic [dqs_pkg::DATA_W-1:0] rdata;
  logic                       res_valid;
  logic                       res_ready;
  dqs_pkg::rsp_beat_t         res;

  dqs_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  dqs_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req_valid),
    .in_beat   (req),
    .in_stall  (req_stall),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready),
    .we        (we),
    .waddr     (waddr),
    .wdata     (wdata),
    .raddr     (raddr),
    .rdata     (rdata)
  );

  assign res_ready = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_ready) begin
      rsp_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      rsp <= res;
    end
  end

endmodule
